@@ rtl/escaped_text_byte_decoder_macros.svh @@
// Assertion macros shared by the escaped text byte decoder RTL.
// Depends on nothing; the using module must provide aclk and aresetn.
`ifndef ESCAPED_TEXT_BYTE_DECODER_MACROS_SVH
`define ESCAPED_TEXT_BYTE_DECODER_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define ETD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define ETD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/etd_pkg.sv @@
// Types, constants and helper functions of the escaped text byte decoder.
// Depends on nothing; used by every module of the block.
package etd_pkg;

    localparam logic [1:0] PHASE_NORMAL = 2'd0;
    localparam logic [1:0] PHASE_ESCAPE = 2'd1;
    localparam logic [1:0] PHASE_NUMBER = 2'd2;
    localparam logic [1:0] PHASE_ERROR  = 2'd3;

    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_data;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       escape_error;
        logic       last_result;
    } out_word_t;

    // Words produced by one input item; res0 is delivered before res1.
    typedef struct packed {
        logic [1:0] res_count;
        out_word_t  res1;
        out_word_t  res0;
    } step_res_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] acc;
    } dec_state_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } esc_hit_t;

    function automatic out_word_t mk_word(logic [7:0] b, logic v, logic e, logic l);
        out_word_t w;
        w.out_byte     = b;
        w.byte_valid   = v;
        w.escape_error = e;
        w.last_result  = l;
        return w;
    endfunction

    // Single-letter escapes and the control codes they stand for.
    function automatic esc_hit_t esc_lookup(logic [7:0] c);
        esc_hit_t r;
        r.hit = 1'b1;
        unique case (c)
            8'h74:   r.value = 8'd9;   // t
            8'h6e:   r.value = 8'd10;  // n
            8'h76:   r.value = 8'd11;  // v
            8'h61:   r.value = 8'd7;   // a
            8'h62:   r.value = 8'd8;   // b
            8'h72:   r.value = 8'd13;  // r
            8'h66:   r.value = 8'd12;  // f
            8'h5c:   r.value = 8'd92;  // backslash
            default: begin
                r.hit   = 1'b0;
                r.value = 8'd0;
            end
        endcase
        return r;
    endfunction

endpackage

@@ rtl/etd_step.sv @@
// Decode logic for one text byte: next decoder state and up to two words.
// Depends on etd_pkg.
module etd_step
    import etd_pkg::*;
(
    input  dec_state_t state_cur,
    input  in_word_t   in_word,
    output dec_state_t state_nxt,
    output step_res_t  step_res
);

    always_comb begin
        logic [7:0] c;
        logic       last;
        logic       digit;
        logic [7:0] dval;
        logic [7:0] acc_mul;
        logic       plain;
        logic [1:0] n;
        esc_hit_t   esc;
        out_word_t  slot [2];

        c       = in_word.in_char;
        last    = in_word.end_of_data;
        digit   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        dval    = c - CHAR_ZERO;
        acc_mul = (state_cur.acc << 3) + (state_cur.acc << 1);
        esc     = esc_lookup(c);
        plain   = 1'b0;
        n       = 2'd0;
        slot[0] = '0;
        slot[1] = '0;
        state_nxt = state_cur;

        unique case (state_cur.phase)
            PHASE_ERROR: begin
                if (last) begin
                    slot[n[0]] = mk_word(8'd0, 1'b0, 1'b1, 1'b1);
                    n = n + 2'd1;
                end
            end
            PHASE_NUMBER: begin
                if (digit) begin
                    state_nxt.acc = acc_mul + dval;
                    if (last) begin
                        slot[n[0]] = mk_word(acc_mul + dval, 1'b1, 1'b0, 1'b1);
                        n = n + 2'd1;
                    end
                end else begin
                    // The run ends here; the terminating byte is decoded as text.
                    slot[n[0]] = mk_word(state_cur.acc, 1'b1, 1'b0, 1'b0);
                    n = n + 2'd1;
                    state_nxt.acc   = 8'd0;
                    state_nxt.phase = PHASE_NORMAL;
                    plain = 1'b1;
                end
            end
            PHASE_ESCAPE: begin
                if (c == CHAR_ZERO) begin
                    state_nxt.phase = PHASE_NORMAL;
                    slot[n[0]] = mk_word(8'd0, 1'b1, 1'b0, last);
                    n = n + 2'd1;
                end else if (esc.hit) begin
                    state_nxt.phase = PHASE_NORMAL;
                    slot[n[0]] = mk_word(esc.value, 1'b1, 1'b0, last);
                    n = n + 2'd1;
                end else if (digit) begin
                    state_nxt.phase = PHASE_NUMBER;
                    state_nxt.acc   = dval;
                    if (last) begin
                        slot[n[0]] = mk_word(dval, 1'b1, 1'b0, 1'b1);
                        n = n + 2'd1;
                    end
                end else begin
                    state_nxt.phase = PHASE_ERROR;
                    slot[n[0]] = mk_word(8'd0, 1'b0, 1'b1, last);
                    n = n + 2'd1;
                end
            end
            default: begin
                plain = 1'b1;
            end
        endcase

        if (plain) begin
            if (c == CHAR_NEWLINE || c == CHAR_TAB) begin
                if (last) begin
                    slot[n[0]] = mk_word(8'd0, 1'b0, 1'b0, 1'b1);
                    n = n + 2'd1;
                end
            end else if (c == CHAR_BACKSLASH) begin
                state_nxt.phase = PHASE_ESCAPE;
                if (last) begin
                    slot[n[0]] = mk_word(8'd0, 1'b0, 1'b1, 1'b1);
                    n = n + 2'd1;
                end
            end else begin
                slot[n[0]] = mk_word(c, 1'b1, 1'b0, last);
                n = n + 2'd1;
            end
        end

        if (last) begin
            state_nxt.phase = PHASE_NORMAL;
            state_nxt.acc   = 8'd0;
        end

        step_res.res_count = n;
        step_res.res0      = slot[0];
        step_res.res1      = slot[1];
    end

endmodule

@@ rtl/etd_out_fifo.sv @@
// Result queue: takes up to two words per cycle, delivers one per cycle while m_ready is high.
// Depends on etd_pkg and escaped_text_byte_decoder_macros.svh.
`include "escaped_text_byte_decoder_macros.svh"
module etd_out_fifo
    import etd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_en,
    input  step_res_t push_res,
    output logic      room_two,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    out_word_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]    count_reg, count_next;
    logic [1:0]               push_n;
    logic                     pop;
    logic [FIFO_PTR_W-1:0]    wr_ptr_p1;
    logic                     push_fits;
    logic                     last_leaving;

    assign push_n    = push_en ? push_res.res_count : 2'd0;
    assign pop       = m_valid && m_ready;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign m_valid   = (count_reg != '0);
    assign m_word    = entry_reg[rd_ptr_reg];
    assign room_two  = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    // Checks only: the fill after a push, and the last stored word leaving.
    assign push_fits = ({1'b0, count_reg} + (FIFO_CNT_W+1)'(push_n))
                       <= (FIFO_CNT_W+1)'(FIFO_DEPTH);
    assign last_leaving = (count_reg == FIFO_CNT_W'(1)) && pop && (push_n == 2'd0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push_res.res0;
        end
        if (push_n == 2'd2) begin
            entry_reg[wr_ptr_p1] <= push_res.res1;
        end
    end

    `ETD_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FIFO_CNT_W'(FIFO_DEPTH), "queue count overflow")
    `ETD_ASSERT_NOW(a_push_fits, push_n != 2'd0, push_fits, "push into a full queue")
    `ETD_ASSERT_NEXT(a_drain_last, last_leaving, !m_valid, "queue not empty after last word left")

endmodule

@@ rtl/escaped_text_byte_decoder.sv @@
// Top level of the escaped text byte decoder: state registers, decode step
// and result queue. Depends on etd_pkg, etd_step, etd_out_fifo and the macros header.
//
// The decoder takes one text byte per word on the s_ channel and hands out
// decoded bytes as words on the m_ channel. Raw newlines and tabs are dropped,
// a backslash opens an escape (0, t n v a b r f, backslash, or a decimal run
// that wraps modulo 256), and an unknown escape flags escape_error and silences
// the rest of the text. The word carrying end_of_data always yields a result
// with last_result set, and it returns the decoder to its reset state. Each
// input word is decoded in the cycle it is accepted, with the decoded words
// landing in a four-entry result queue, so the input side takes one word per
// cycle while s_ready is high. One input word yields zero, one or two results;
// the queue delivers one result per cycle while m_ready is high, and s_ready
// stays high while the queue holds two words or fewer. A stream that keeps yielding
// two results per input therefore runs at the output rate of one result per cycle.
`include "escaped_text_byte_decoder_macros.svh"
module escaped_text_byte_decoder
    import etd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    dec_state_t state_reg;
    dec_state_t state_next;
    step_res_t  step_res;
    logic       s_accept;
    logic       room_two;
    logic       end_accept;
    logic       end_marked;
    logic       state_clear;

    // The ready depends only on the queue fill, never on m_ready.
    assign s_ready  = room_two;
    assign s_accept = s_valid && s_ready;

    etd_step u_step (
        .state_cur (state_reg),
        .in_word   (s_word),
        .state_nxt (state_next),
        .step_res  (step_res)
    );

    // Decoder state moves only when a word is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase <= PHASE_NORMAL;
            state_reg.acc   <= 8'd0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    etd_out_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_en  (s_accept),
        .push_res (step_res),
        .room_two (room_two),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word)
    );

    // Checks only: the end of a text must carry the last mark on its final
    // word and leave the decoder in its reset state.
    assign end_accept  = s_accept && s_word.end_of_data;
    assign end_marked  = (step_res.res_count != 2'd0) &&
                         ((step_res.res_count == 2'd2) ? step_res.res1.last_result
                                                       : step_res.res0.last_result);
    assign state_clear = (state_reg.phase == PHASE_NORMAL) && (state_reg.acc == 8'd0);

    `ETD_ASSERT_NOW(a_end_has_result, end_accept, end_marked, "end of text without last result")
    `ETD_ASSERT_NEXT(a_end_resets, end_accept, state_clear, "state not cleared after end of text")

endmodule
